// ----- hdl/itcf_pkg.sv -----
// itcf_pkg: shared types and constants of the tilt complementary filter
// register map, reset values, cordic arctangent table and the controller command bundle
// no dependencies
`default_nettype none

package itcf_pkg;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_ADDR_W-1:0] REG_GYRO_BIAS    = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_ACCEL_OFFSET = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_GYRO_GAIN    = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_BLEND_WEIGHT = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_TILT_LIMIT   = 3'd4;

   localparam logic signed [10:0] RST_GYRO_BIAS    = 11'sd14;
   localparam logic signed [12:0] RST_ACCEL_OFFSET = 13'sd640;
   localparam logic [15:0]        RST_GYRO_GAIN    = 16'd10240;
   localparam logic [15:0]        RST_BLEND_WEIGHT = 16'd655;
   localparam logic [15:0]        RST_TILT_LIMIT   = 16'd12800;

   typedef struct packed {
      logic signed [10:0] gyro_bias;
      logic signed [12:0] accel_angle_offset;
      logic [15:0]        gyro_gain;
      logic [15:0]        blend_weight;
      logic [15:0]        tilt_limit;
   } cfg_type;

   // cordic: inputs scaled by 2^14, angle accumulator in 2^-20 degree
   localparam int IN_SHIFT  = 14;
   localparam int ACC_FRAC  = 20;
   localparam int TABLE_LEN = 24;
   localparam int ITER_W    = 5;
   localparam int XY_W      = 33;
   localparam int Z_W       = 31;
   localparam int TAB_W     = 27;

   localparam logic signed [Z_W-1:0] HALF_TURN = 31'sd188743680;

   typedef logic [TAB_W-1:0] atan_tab_type [TABLE_LEN];

   localparam atan_tab_type ATAN_TAB = '{
      27'd47185920, 27'd27855475, 27'd14718068, 27'd7471121,
      27'd3750058,  27'd1876857,  27'd938658,   27'd469357,
      27'd234682,   27'd117342,   27'd58671,    27'd29335,
      27'd14668,    27'd7334,     27'd3667,     27'd1833,
      27'd917,      27'd458,      27'd229,      27'd115,
      27'd57,       27'd29,       27'd14,       27'd7
   };

   typedef struct packed {
      logic              load;
      logic              cordic;
      logic [ITER_W-1:0] iter;
      logic              gstep;
      logic              gadd;
      logic              mixa;
      logic              mixb;
      logic              sat;
      logic              finish;
   } cmd_type;

endpackage

`default_nettype wire

// ----- hdl/itcf_csr.sv -----
// itcf_csr: configuration registers of the tilt filter
// depends on itcf_pkg for the register map and reset values
`default_nettype none

module itcf_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_wr_en,
   input  wire logic [itcf_pkg::CSR_ADDR_W-1:0]  csr_index,
   input  wire logic [itcf_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output itcf_pkg::cfg_type                     cfg
);

   itcf_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            itcf_pkg::REG_GYRO_BIAS:    cfg_in.gyro_bias          = csr_wdata[10:0];
            itcf_pkg::REG_ACCEL_OFFSET: cfg_in.accel_angle_offset = csr_wdata[12:0];
            itcf_pkg::REG_GYRO_GAIN:    cfg_in.gyro_gain          = csr_wdata;
            itcf_pkg::REG_BLEND_WEIGHT: cfg_in.blend_weight       = csr_wdata;
            itcf_pkg::REG_TILT_LIMIT:   cfg_in.tilt_limit         = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gyro_bias          <= itcf_pkg::RST_GYRO_BIAS;
         cfg_ff.accel_angle_offset <= itcf_pkg::RST_ACCEL_OFFSET;
         cfg_ff.gyro_gain          <= itcf_pkg::RST_GYRO_GAIN;
         cfg_ff.blend_weight       <= itcf_pkg::RST_BLEND_WEIGHT;
         cfg_ff.tilt_limit         <= itcf_pkg::RST_TILT_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- hdl/itcf_ctrl.sv -----
// itcf_ctrl: sequencer of the tilt filter, drives the datapath by commands
// owns the handshakes and the cordic iteration count; depends on itcf_pkg
`default_nettype none

module itcf_ctrl #(
   parameter int CORDIC_ITERATIONS = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output itcf_pkg::cmd_type cmd
);

   localparam int N_ITER = (CORDIC_ITERATIONS < itcf_pkg::TABLE_LEN) ?
                           CORDIC_ITERATIONS : itcf_pkg::TABLE_LEN;
   localparam logic [itcf_pkg::ITER_W-1:0] LAST_ITER = itcf_pkg::ITER_W'(N_ITER - 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CORDIC = 3'd1;
   localparam logic [2:0] ST_GSTEP  = 3'd2;
   localparam logic [2:0] ST_GADD   = 3'd3;
   localparam logic [2:0] ST_MIXA   = 3'd4;
   localparam logic [2:0] ST_MIXB   = 3'd5;
   localparam logic [2:0] ST_SAT    = 3'd6;
   localparam logic [2:0] ST_FIN    = 3'd7;

   logic [2:0]                  state_ff, state_in;
   logic [itcf_pkg::ITER_W-1:0] iter_ff, iter_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      iter_in   = iter_ff;
      cmd       = '0;
      cmd.iter  = iter_ff;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               iter_in  = '0;
               state_in = ST_CORDIC;
            end
         end
         ST_CORDIC: begin
            cmd.cordic = 1'b1;
            if (iter_ff == LAST_ITER) begin
               state_in = ST_GSTEP;
            end else begin
               iter_in = iter_ff + 1'b1;
            end
         end
         ST_GSTEP: begin
            cmd.gstep = 1'b1;
            state_in  = ST_GADD;
         end
         ST_GADD: begin
            cmd.gadd = 1'b1;
            state_in = ST_MIXA;
         end
         ST_MIXA: begin
            cmd.mixa = 1'b1;
            state_in = ST_MIXB;
         end
         ST_MIXB: begin
            cmd.mixb = 1'b1;
            state_in = ST_SAT;
         end
         ST_SAT: begin
            cmd.sat  = 1'b1;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            // wait for the output register to be free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ----- hdl/itcf_datapath.sv -----
// itcf_datapath: cordic atan2, shared multiplier, blend and saturation of the tilt filter
// holds the kept angle and the output register; depends on itcf_pkg
`default_nettype none

module itcf_datapath #(
   parameter int ANGLE_FRAC_BITS = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire itcf_pkg::cmd_type  cmd,
   input  wire itcf_pkg::cfg_type  cfg,
   input  wire logic signed [15:0] req_accel_x,
   input  wire logic signed [15:0] req_accel_z,
   input  wire logic signed [15:0] req_gyro_y,
   output logic signed [16:0]      rsp_tilt_angle,
   output logic                    rsp_tilt_exceeded
);

   localparam int XY_W  = itcf_pkg::XY_W;
   localparam int Z_W   = itcf_pkg::Z_W;
   localparam int SH    = itcf_pkg::ACC_FRAC - ANGLE_FRAC_BITS;
   localparam int RND   = 1 << (SH - 1);
   // 180 degrees fits below 2^(frac+8)
   localparam int ANG_W = ANGLE_FRAC_BITS + 9;
   localparam int LIM   = 180 << ANGLE_FRAC_BITS;
   localparam int A_W   = ANG_W + 3;
   localparam int G_W   = ((ANG_W > 18) ? ANG_W : 18) + 1;
   localparam int MA_W  = (A_W > G_W) ? A_W : G_W;
   localparam int MB_W  = 18;
   localparam int P_W   = MA_W + MB_W;
   localparam int S_W   = P_W + 1;
   localparam int M_W   = MA_W + 1;
   localparam int C_W   = ((ANG_W > 17) ? ANG_W : 17) + 1;

   logic signed [XY_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [Z_W-1:0]  z_ff, z_in;
   logic                   zero_ff, zero_in;
   logic signed [16:0]     gyb_ff, gyb_in;
   logic signed [A_W-1:0]  acc_ff, acc_in;
   logic signed [P_W-1:0]  prod_ff, prod_in;
   logic signed [G_W-1:0]  gyro_ff, gyro_in;
   logic signed [S_W-1:0]  sum_ff, sum_in;
   logic signed [ANG_W-1:0] mix_ff, mix_in, filt_ff, filt_in;
   logic signed [16:0]     tilt_ff, tilt_in;
   logic                   exc_ff, exc_in;

   // load
   logic signed [XY_W-1:0] x_ld, y_ld;
   // cordic step
   logic signed [XY_W-1:0] dx, dy;
   logic signed [Z_W-1:0]  tab;
   // rounding of the accumulated angle
   logic signed [Z_W:0]    z_rnd, z_sh;
   logic signed [ANG_W:0]  atan_q;
   // shared multiplier
   logic signed [MA_W-1:0] mul_a;
   logic signed [MB_W-1:0] mul_b;
   logic signed [P_W-1:0]  mul_p;
   logic signed [P_W-1:0]  prod_rnd;
   logic signed [17:0]     gstep_q;
   // saturation and limit
   logic signed [S_W-1:0]  sum_sh;
   logic signed [M_W-1:0]  mix_w;
   logic signed [C_W-1:0]  mix_c, lim_c;
   logic signed [ANG_W+16:0] tilt_w;

   assign x_ld = {{(XY_W-30){req_accel_z[15]}}, req_accel_z, {itcf_pkg::IN_SHIFT{1'b0}}};
   assign y_ld = {{(XY_W-30){req_accel_x[15]}}, req_accel_x, {itcf_pkg::IN_SHIFT{1'b0}}};

   assign dx  = y_ff >>> cmd.iter;
   assign dy  = x_ff >>> cmd.iter;
   assign tab = Z_W'(itcf_pkg::ATAN_TAB[cmd.iter]);

   assign z_rnd  = (Z_W+1)'(z_ff) + (Z_W+1)'(RND);
   assign z_sh   = z_rnd >>> SH;
   assign atan_q = z_sh[ANG_W:0];

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (cmd.gstep) begin
         mul_a = MA_W'(gyb_ff);
         mul_b = MB_W'(cfg.gyro_gain);
      end else if (cmd.gadd) begin
         mul_a = MA_W'(acc_ff);
         mul_b = MB_W'(cfg.blend_weight);
      end else if (cmd.mixa) begin
         mul_a = MA_W'(gyro_ff);
         mul_b = 18'sd65536 - MB_W'(cfg.blend_weight);
      end
   end

   assign mul_p    = P_W'(mul_a) * P_W'(mul_b);
   assign prod_rnd = prod_ff + P_W'(32768);
   assign gstep_q  = prod_rnd[33:16];

   assign sum_sh = sum_ff >>> 16;
   assign mix_w  = sum_sh[M_W-1:0];

   assign mix_c  = C_W'(mix_ff);
   assign lim_c  = C_W'(cfg.tilt_limit);
   assign tilt_w = (ANG_W+17)'(mix_ff);

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      zero_in = zero_ff;
      gyb_in  = gyb_ff;
      acc_in  = acc_ff;
      prod_in = prod_ff;
      gyro_in = gyro_ff;
      sum_in  = sum_ff;
      mix_in  = mix_ff;
      filt_in = filt_ff;
      tilt_in = tilt_ff;
      exc_in  = exc_ff;

      if (cmd.load) begin
         zero_in = (req_accel_x == 16'sd0) && (req_accel_z == 16'sd0);
         gyb_in  = 17'(req_gyro_y) + 17'(cfg.gyro_bias);
         if (x_ld < 0) begin
            // left half plane: turn by half a circle first
            x_in = -x_ld;
            y_in = -y_ld;
            z_in = (y_ld >= 0) ? itcf_pkg::HALF_TURN : -itcf_pkg::HALF_TURN;
         end else begin
            x_in = x_ld;
            y_in = y_ld;
            z_in = '0;
         end
      end

      if (cmd.cordic) begin
         if (y_ff >= 0) begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + tab;
         end else begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - tab;
         end
      end

      if (cmd.gstep) begin
         prod_in = mul_p;
         if (zero_ff) begin
            acc_in = A_W'(cfg.accel_angle_offset);
         end else begin
            acc_in = A_W'(cfg.accel_angle_offset) - A_W'(atan_q);
         end
      end

      if (cmd.gadd) begin
         gyro_in = G_W'(filt_ff) + G_W'(gstep_q);
         prod_in = mul_p;
      end

      if (cmd.mixa) begin
         sum_in  = S_W'(prod_ff);
         prod_in = mul_p;
      end

      if (cmd.mixb) begin
         sum_in = sum_ff + S_W'(prod_ff) + S_W'(32768);
      end

      if (cmd.sat) begin
         if (mix_w > M_W'(LIM)) begin
            mix_in = ANG_W'(LIM);
         end else if (mix_w < -M_W'(LIM)) begin
            mix_in = -ANG_W'(LIM);
         end else begin
            mix_in = mix_w[ANG_W-1:0];
         end
      end

      if (cmd.finish) begin
         filt_in = mix_ff;
         tilt_in = tilt_w[16:0];
         exc_in  = (mix_c > lim_c) || (mix_c < -lim_c);
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      zero_ff <= zero_in;
      gyb_ff  <= gyb_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      gyro_ff <= gyro_in;
      sum_ff  <= sum_in;
      mix_ff  <= mix_in;
      tilt_ff <= tilt_in;
      exc_ff  <= exc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filt_ff <= '0;
      end else begin
         filt_ff <= filt_in;
      end
   end

   assign rsp_tilt_angle    = tilt_ff;
   assign rsp_tilt_exceeded = exc_ff;

endmodule

`default_nettype wire

// ----- hdl/imu_tilt_complementary_filter.sv -----
// imu_tilt_complementary_filter: one-axis tilt estimator for accelerometer and gyro samples
// takes one sample transaction on req_, returns the filtered angle on rsp_,
// registers on csr_. the req channel carries accel x/z and gyro y, the rsp channel
// the angle in 2^-ANGLE_FRAC_BITS degree and the over-limit flag.
// csr_ is a plain write port (enable, index, data); the user must write it only
// while idle, which the block does not enforce. one sample is worked on at a time:
// the cordic loop uses min(CORDIC_ITERATIONS, 24) table entries, then a shared
// multiplier does the gyro step and both blend products, then saturation and limit
// check. a new sample is taken only once the previous one has finished.
// the result sits in an output register; if the receiver stalls, the next sample
// is still accepted and computed, and waits in its last step until the register frees.
// synchronous reset clears the kept angle to zero, drops rsp_valid and loads
// the register reset values.
// depends on itcf_pkg, itcf_csr, itcf_ctrl, itcf_datapath
`default_nettype none

module imu_tilt_complementary_filter #(
   parameter int CORDIC_ITERATIONS = 16,
   parameter int ANGLE_FRAC_BITS   = 8
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic signed [15:0]              req_accel_x,
   input  wire logic signed [15:0]              req_accel_z,
   input  wire logic signed [15:0]              req_gyro_y,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic signed [16:0]                   rsp_tilt_angle,
   output logic                                 rsp_tilt_exceeded,
   input  wire logic                            csr_wr_en,
   input  wire logic [itcf_pkg::CSR_ADDR_W-1:0] csr_index,
   input  wire logic [itcf_pkg::CSR_DATA_W-1:0] csr_wdata
);

   itcf_pkg::cfg_type cfg;
   itcf_pkg::cmd_type cmd;

   itcf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   itcf_ctrl #(
      .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   itcf_datapath #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .cfg               (cfg),
      .req_accel_x       (req_accel_x),
      .req_accel_z       (req_accel_z),
      .req_gyro_y        (req_gyro_y),
      .rsp_tilt_angle    (rsp_tilt_angle),
      .rsp_tilt_exceeded (rsp_tilt_exceeded)
   );

endmodule

`default_nettype wire

// ----- bench/tb_imu_tilt_complementary_filter.sv -----
`timescale 1ns / 1ps
// tb_imu_tilt_complementary_filter: self-checking bench for the tilt complementary filter
// drives imu sample transactions, predicts angle and limit flag, checks the rsp channel
// depends on itcf_pkg and imu_tilt_complementary_filter

module tb_imu_tilt_complementary_filter;

   localparam int     CORDIC_ITERS    = 16;
   localparam int     FRAC_BITS       = 8;
   localparam int     ACC_BITS        = 20;
   localparam longint ANGLE_CLAMP     = longint'(180) <<< FRAC_BITS;
   localparam int     ITEMS_PER_PHASE = 250;
   localparam int     NUM_PHASES      = 6;

   typedef enum logic {ROW_SAMPLE, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type       kind;
      logic [2:0]         idx;
      logic [15:0]        data;
      logic signed [15:0] ax;
      logic signed [15:0] az;
      logic signed [15:0] gy;
      bit                 typed;
      logic signed [16:0] angle;
      logic               flag;
   } stim_row_type;

   typedef struct {
      logic signed [16:0] angle;
      logic               exceeded;
   } tilt_result_type;

   logic                                 clock;
   logic                                 reset;
   logic                                 req_valid;
   logic                                 req_ready;
   logic signed [15:0]                   req_accel_x;
   logic signed [15:0]                   req_accel_z;
   logic signed [15:0]                   req_gyro_y;
   logic                                 rsp_valid;
   logic                                 rsp_ready;
   logic signed [16:0]                   rsp_tilt_angle;
   logic                                 rsp_tilt_exceeded;
   logic                                 csr_wr_en;
   logic [itcf_pkg::CSR_ADDR_W-1:0]      csr_index;
   logic [itcf_pkg::CSR_DATA_W-1:0]      csr_wdata;

   // register shadows and kept angle of the predictor
   logic signed [10:0] cfg_bias;
   logic signed [12:0] cfg_offset;
   logic [15:0]        cfg_gain;
   logic [15:0]        cfg_weight;
   logic [15:0]        cfg_limit;
   longint             kept_angle;

   tilt_result_type expected_tilt[$];
   stim_row_type    directed[$];
   int              mismatches;
   int              send_idle_pct;
   int              recv_idle_pct;

   imu_tilt_complementary_filter #(
      .CORDIC_ITERATIONS(CORDIC_ITERS),
      .ANGLE_FRAC_BITS  (FRAC_BITS)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_accel_x      (req_accel_x),
      .req_accel_z      (req_accel_z),
      .req_gyro_y       (req_gyro_y),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_tilt_angle   (rsp_tilt_angle),
      .rsp_tilt_exceeded(rsp_tilt_exceeded),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // arctangent of 2^-i in 2^-20 degree
   function automatic longint atan_step(input int i);
      case (i)
         0:  return 47185920;
         1:  return 27855475;
         2:  return 14718068;
         3:  return 7471121;
         4:  return 3750058;
         5:  return 1876857;
         6:  return 938658;
         7:  return 469357;
         8:  return 234682;
         9:  return 117342;
         10: return 58671;
         11: return 29335;
         12: return 14668;
         13: return 7334;
         14: return 3667;
         15: return 1833;
         16: return 917;
         17: return 458;
         18: return 229;
         19: return 115;
         20: return 57;
         21: return 29;
         22: return 14;
         default: return 7;
      endcase
   endfunction

   // atan2(ax, az) in angle units, vectoring cordic on inputs scaled by 2^14
   function automatic longint accel_atan(input longint ax, input longint az);
      longint x, y, z, dx, dy;
      int     i;
      if (ax == 0 && az == 0)
         return 0;
      x = az * 16384;
      y = ax * 16384;
      z = 0;
      if (x < 0) begin
         z = (y >= 0) ? (longint'(180) <<< ACC_BITS) : -(longint'(180) <<< ACC_BITS);
         x = -x;
         y = -y;
      end
      for (i = 0; i < CORDIC_ITERS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x = x + dx;
            y = y - dy;
            z = z + atan_step(i);
         end else begin
            x = x - dx;
            y = y + dy;
            z = z - atan_step(i);
         end
      end
      return (z + (longint'(1) <<< (ACC_BITS - FRAC_BITS - 1))) >>> (ACC_BITS - FRAC_BITS);
   endfunction

   // one filter step: updates the kept angle and returns the emitted result
   function automatic tilt_result_type filter_step(input logic signed [15:0] ax,
                                                   input logic signed [15:0] az,
                                                   input logic signed [15:0] gy);
      longint          acc, gyro_est, mix, w, lim;
      tilt_result_type res;
      w        = longint'(cfg_weight);
      lim      = longint'(cfg_limit);
      acc      = -accel_atan(longint'(ax), longint'(az)) + longint'(cfg_offset);
      gyro_est = kept_angle
               + (((longint'(gy) + longint'(cfg_bias)) * longint'(cfg_gain) + 32768) >>> 16);
      mix      = (w * acc + (65536 - w) * gyro_est + 32768) >>> 16;
      if (mix > ANGLE_CLAMP)
         mix = ANGLE_CLAMP;
      if (mix < -ANGLE_CLAMP)
         mix = -ANGLE_CLAMP;
      kept_angle   = mix;
      res.angle    = mix[16:0];
      res.exceeded = (mix > lim || mix < -lim);
      return res;
   endfunction

   function automatic stim_row_type sample_row(input int ax, input int az, input int gy);
      stim_row_type r;
      r       = '{kind: ROW_SAMPLE, default: '0};
      r.ax    = ax[15:0];
      r.az    = az[15:0];
      r.gy    = gy[15:0];
      r.typed = 1'b0;
      return r;
   endfunction

   function automatic stim_row_type known_row(input int ax, input int az, input int gy,
                                              input int angle, input bit flag);
      stim_row_type r;
      r       = sample_row(ax, az, gy);
      r.typed = 1'b1;
      r.angle = angle[16:0];
      r.flag  = flag;
      return r;
   endfunction

   function automatic stim_row_type csr_row(input logic [2:0] idx, input int data);
      stim_row_type r;
      r      = '{kind: ROW_CSR, default: '0};
      r.idx  = idx;
      r.data = data[15:0];
      return r;
   endfunction

   function automatic logic [15:0] pick_setting(input logic [2:0] idx);
      int r, v;
      r = $urandom_range(9);
      v = $urandom_range(65535);
      case (idx)
         itcf_pkg::REG_GYRO_BIAS: begin
            if (r == 0) v = -1024;
            else if (r == 1) v = 1023;
            else if (r > 2) v = $urandom_range(2047) - 1024;
         end
         itcf_pkg::REG_ACCEL_OFFSET: begin
            if (r == 0) v = -2560;
            else if (r == 1) v = 2560;
            else if (r > 2) v = $urandom_range(5120) - 2560;
         end
         itcf_pkg::REG_TILT_LIMIT: begin
            if (r == 0) v = 0;
            else if (r == 1) v = 46080;
            else if (r > 2) v = $urandom_range(46080);
         end
         default: begin
            if (r == 0) v = 0;
            else if (r == 1) v = 65535;
         end
      endcase
      return v[15:0];
   endfunction

   function automatic logic [15:0] pick_extreme();
      case ($urandom_range(4))
         0: return 16'h8000;
         1: return 16'hFFFF;
         2: return 16'h0000;
         3: return 16'h0001;
         default: return 16'h7FFF;
      endcase
   endfunction

   task report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch on %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   // hold the sender until every outstanding transaction has come back
   task drain_results();
      req_valid <= 1'b0;
      while (expected_tilt.size() > 0)
         @(posedge clock);
   endtask

   task write_reg(input logic [2:0] idx, input logic [15:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         itcf_pkg::REG_GYRO_BIAS:    cfg_bias   = data[10:0];
         itcf_pkg::REG_ACCEL_OFFSET: cfg_offset = data[12:0];
         itcf_pkg::REG_GYRO_GAIN:    cfg_gain   = data;
         itcf_pkg::REG_BLEND_WEIGHT: cfg_weight = data;
         itcf_pkg::REG_TILT_LIMIT:   cfg_limit  = data;
         default: ;
      endcase
   endtask

   task send_sample(input logic signed [15:0] ax, input logic signed [15:0] az,
                    input logic signed [15:0] gy, input bit typed,
                    input tilt_result_type known);
      tilt_result_type predicted;
      csr_wr_en <= 1'b0;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_accel_x <= ax;
      req_accel_z <= az;
      req_gyro_y  <= gy;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      predicted = filter_step(ax, az, gy);
      expected_tilt.push_back(typed ? known : predicted);
   endtask

   task random_sample();
      logic [15:0]     ax, az, gy;
      int              r;
      tilt_result_type none;
      none = '{default: '0};
      r    = $urandom_range(99);
      gy   = 16'($urandom);
      if (r < 70) begin
         ax = 16'($urandom);
         az = 16'($urandom);
      end else if (r < 85) begin
         ax = 16'($urandom_range(127) - 64);
         az = 16'($urandom_range(127) - 64);
         gy = 16'($urandom_range(127) - 64);
      end else if (r < 95) begin
         ax = pick_extreme();
         az = pick_extreme();
         gy = pick_extreme();
      end else begin
         ax = '0;
         az = '0;
      end
      send_sample(ax, az, gy, 1'b0, none);
   endtask

   // receiver: random stalls, each accepted transaction checked against the oldest prediction
   always @(posedge clock) begin
      tilt_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_tilt.size() == 0) begin
               report_mismatch("unexpected tilt_angle", longint'(rsp_tilt_angle), 0);
            end else begin
               want = expected_tilt.pop_front();
               if (rsp_tilt_angle !== want.angle)
                  report_mismatch("tilt_angle", longint'(rsp_tilt_angle), longint'(want.angle));
               if (rsp_tilt_exceeded !== want.exceeded)
                  report_mismatch("tilt_exceeded", longint'(rsp_tilt_exceeded),
                                  longint'(want.exceeded));
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin
      #5_000_000;
      $display("imu_tilt_complementary_filter verification failed");
      $finish;
   end

   initial begin
      tilt_result_type known;
      int              i, phase, k;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_accel_x   = '0;
      req_accel_z   = '0;
      req_gyro_y    = '0;
      rsp_ready     = 1'b0;
      csr_wr_en     = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      mismatches    = 0;
      cfg_bias      = itcf_pkg::RST_GYRO_BIAS;
      cfg_offset    = itcf_pkg::RST_ACCEL_OFFSET;
      cfg_gain      = itcf_pkg::RST_GYRO_GAIN;
      cfg_weight    = itcf_pkg::RST_BLEND_WEIGHT;
      cfg_limit     = itcf_pkg::RST_TILT_LIMIT;
      kept_angle    = 0;
      send_idle_pct = 27;
      recv_idle_pct = 88;

      directed = '{
         // both accel axes zero, gyro cancels the reset bias
         known_row(0, 0, -14, 6, 1'b0),
         sample_row(32767, 0, 0),
         sample_row(-32768, 0, 0),
         // negative z: turn counts +180 for x >= 0, -180 for x < 0
         sample_row(0, -32768, 0),
         sample_row(-1, -32768, 0),
         sample_row(32767, -1, 1),
         sample_row(0, 32767, 32767),
         sample_row(-32768, -32768, -32768),
         // pure gyro integration at full gain drives the angle into saturation
         csr_row(itcf_pkg::REG_GYRO_GAIN, 65535),
         csr_row(itcf_pkg::REG_BLEND_WEIGHT, 0),
         csr_row(itcf_pkg::REG_GYRO_BIAS, 1023),
         sample_row(0, 16384, 32767),
         sample_row(0, 16384, 32767),
         known_row(0, 16384, 32767, 46080, 1'b1),
         sample_row(0, 16384, -32768),
         sample_row(0, 16384, -32768),
         known_row(0, 16384, -32768, -46080, 1'b1),
         csr_row(itcf_pkg::REG_GYRO_BIAS, -1024),
         csr_row(itcf_pkg::REG_ACCEL_OFFSET, -2560),
         csr_row(itcf_pkg::REG_BLEND_WEIGHT, 65535),
         csr_row(itcf_pkg::REG_GYRO_GAIN, 0),
         csr_row(itcf_pkg::REG_TILT_LIMIT, 0),
         sample_row(0, 0, 0),
         sample_row(1, -1, -1),
         sample_row(-1, 1, 0)
      };

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         if (directed[i].kind == ROW_CSR) begin
            drain_results();
            write_reg(directed[i].idx, directed[i].data);
         end else begin
            known.angle    = directed[i].angle;
            known.exceeded = directed[i].flag;
            send_sample(directed[i].ax, directed[i].az, directed[i].gy,
                        directed[i].typed, known);
         end
      end

      for (phase = 0; phase < NUM_PHASES; phase++) begin
         send_idle_pct = (phase < 2) ? 27 : (phase < 4) ? 88 : 0;
         recv_idle_pct = (phase < 2) ? 88 : (phase < 4) ? 27 : 0;
         drain_results();
         for (k = itcf_pkg::REG_GYRO_BIAS; k <= itcf_pkg::REG_TILT_LIMIT; k++)
            write_reg(k[2:0], pick_setting(k[2:0]));
         for (i = 0; i < ITEMS_PER_PHASE; i++) begin
            if (i == 100 && (phase == 0 || phase == 3))
               drain_results();
            random_sample();
         end
      end

      drain_results();
      repeat (40) @(posedge clock);
      if (mismatches == 0)
         $display("imu_tilt_complementary_filter verification clean");
      else
         $display("imu_tilt_complementary_filter verification failed");
      $finish;
   end

endmodule
